@@ src/knm_pkg.sv @@
// Package: shared constants, types and knight offset tables for the knight path search.
package knm_pkg;

    localparam int MAX_DIM_DEF = 128;
    localparam int COORD_W     = 7;
    localparam int CFG_W       = 8;
    localparam int COUNT_W     = 14;
    localparam int CELL_W      = COUNT_W + 1;

    // register codes, taken from paddr[2]
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SEED,
        ST_POP,
        ST_LOAD,
        ST_NB_CALC,
        ST_NB_CHECK,
        ST_LOOK,
        ST_LOOK_WAIT,
        ST_DONE
    } state_t;

    // write strobes from the sequencer to the stores
    typedef struct packed {
        logic mem_we;
        logic q_we;
    } store_ctl_t;

    // row offset of knight move k
    function automatic logic signed [2:0] step_dr(input logic [2:0] k);
        case (k)
            3'd0: step_dr = 3'sd2;
            3'd1: step_dr = 3'sd2;
            3'd2: step_dr = -3'sd2;
            3'd3: step_dr = -3'sd2;
            3'd4: step_dr = 3'sd1;
            3'd5: step_dr = -3'sd1;
            3'd6: step_dr = -3'sd1;
            3'd7: step_dr = 3'sd1;
            default: step_dr = 3'sd0;
        endcase
    endfunction

    // column offset of knight move k
    function automatic logic signed [2:0] step_dc(input logic [2:0] k);
        case (k)
            3'd0: step_dc = 3'sd1;
            3'd1: step_dc = -3'sd1;
            3'd2: step_dc = -3'sd1;
            3'd3: step_dc = 3'sd1;
            3'd4: step_dc = 3'sd2;
            3'd5: step_dc = 3'sd2;
            3'd6: step_dc = -3'sd2;
            3'd7: step_dc = -3'sd2;
            default: step_dc = 3'sd0;
        endcase
    endfunction

endpackage

@@ src/knm_step_unit.sv @@
// Shared neighbor unit: applies one knight offset and checks the result against the board.
module knm_step_unit #(
    parameter int MAX_DIM = knm_pkg::MAX_DIM_DEF,
    parameter int DIM_W   = $clog2(MAX_DIM),
    parameter int ROWS_W  = $clog2(MAX_DIM + 1)
) (
    input  logic [DIM_W-1:0]  cur_row,
    input  logic [DIM_W-1:0]  cur_col,
    input  logic [2:0]        k,
    input  logic [ROWS_W-1:0] rows,
    input  logic [ROWS_W-1:0] cols,
    output logic [DIM_W-1:0]  nb_row,
    output logic [DIM_W-1:0]  nb_col,
    output logic              on_board
);
    localparam int NW = DIM_W + 2;

    logic signed [NW-1:0] nr;
    logic signed [NW-1:0] nc;

    // signed add of the offset, then bounds compare
    assign nr = $signed({2'b00, cur_row}) + NW'(knm_pkg::step_dr(k));
    assign nc = $signed({2'b00, cur_col}) + NW'(knm_pkg::step_dc(k));

    assign on_board = !nr[NW-1] && !nc[NW-1]
                   && ($unsigned(nr) < NW'(rows)) && ($unsigned(nc) < NW'(cols));
    assign nb_row = nr[DIM_W-1:0];
    assign nb_col = nc[DIM_W-1:0];

endmodule

@@ src/knm_store.sv @@
// Square store (visited flag plus distance) and square queue memories.
module knm_store #(
    parameter int MAX_DIM = knm_pkg::MAX_DIM_DEF,
    parameter int IDX_W   = 2 * $clog2(MAX_DIM),
    parameter int Q_W     = knm_pkg::COUNT_W + IDX_W
) (
    input  logic                       aclk,
    input  knm_pkg::store_ctl_t        ctl,
    input  logic [IDX_W-1:0]           mem_addr,
    input  logic [knm_pkg::CELL_W-1:0] mem_wdata,
    output logic [knm_pkg::CELL_W-1:0] mem_rdata,
    input  logic [IDX_W-1:0]           q_waddr,
    input  logic [Q_W-1:0]             q_wdata,
    input  logic [IDX_W-1:0]           q_raddr,
    output logic [Q_W-1:0]             q_rdata
);
    localparam int DEPTH = 1 << IDX_W;

    logic [knm_pkg::CELL_W-1:0] cell_mem [DEPTH];
    logic [Q_W-1:0]             q_mem [DEPTH];
    logic [knm_pkg::CELL_W-1:0] mem_rd_reg;
    logic [Q_W-1:0]             q_rd_reg;

    // square store: one port, read before write
    always_ff @(posedge aclk) begin
        if (ctl.mem_we) begin
            cell_mem[mem_addr] <= mem_wdata;
        end
        mem_rd_reg <= cell_mem[mem_addr];
    end

    // queue: one write port, one read port
    always_ff @(posedge aclk) begin
        if (ctl.q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_rd_reg <= q_mem[q_raddr];
    end

    assign mem_rdata = mem_rd_reg;
    assign q_rdata   = q_rd_reg;

endmodule

@@ src/knm_ctrl.sv @@
// Search sequencer: clear sweep, queue walk, neighbor checks and final lookup.
module knm_ctrl #(
    parameter int MAX_DIM = knm_pkg::MAX_DIM_DEF,
    parameter int DIM_W   = $clog2(MAX_DIM),
    parameter int ROWS_W  = $clog2(MAX_DIM + 1),
    parameter int IDX_W   = 2 * DIM_W,
    parameter int Q_W     = knm_pkg::COUNT_W + IDX_W
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [ROWS_W-1:0]            rows,
    input  logic [ROWS_W-1:0]            cols,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [knm_pkg::COORD_W-1:0]  start_row,
    input  logic [knm_pkg::COORD_W-1:0]  start_col,
    input  logic [knm_pkg::COORD_W-1:0]  dest_row,
    input  logic [knm_pkg::COORD_W-1:0]  dest_col,
    input  logic                         out_free,
    output logic                         res_load,
    output logic                         res_reachable,
    output logic [knm_pkg::COUNT_W-1:0]  res_count,
    output knm_pkg::store_ctl_t          ctl,
    output logic [IDX_W-1:0]             mem_addr,
    output logic [knm_pkg::CELL_W-1:0]   mem_wdata,
    input  logic [knm_pkg::CELL_W-1:0]   mem_rdata,
    output logic [IDX_W-1:0]             q_waddr,
    output logic [Q_W-1:0]               q_wdata,
    output logic [IDX_W-1:0]             q_raddr,
    input  logic [Q_W-1:0]               q_rdata
);
    localparam int DEPTH = 1 << IDX_W;
    localparam int QC_W  = IDX_W + 1;
    localparam int CMP_W = (ROWS_W > knm_pkg::CFG_W) ? ROWS_W : knm_pkg::CFG_W;
    localparam int CW    = knm_pkg::COUNT_W;

    knm_pkg::state_t state_reg, state_next;
    logic [DIM_W-1:0] start_row_reg, start_row_next, start_col_reg, start_col_next;
    logic [DIM_W-1:0] dest_row_reg, dest_row_next, dest_col_reg, dest_col_next;
    logic [DIM_W-1:0] cur_row_reg, cur_row_next, cur_col_reg, cur_col_next;
    logic [CW-1:0]    cur_dist_reg, cur_dist_next;
    logic [2:0]       k_reg, k_next;
    logic [QC_W-1:0]  head_reg, head_next, tail_reg, tail_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic             reach_reg, reach_next;
    logic [CW-1:0]    count_reg, count_next;

    logic [CMP_W-1:0] sr_ext, sc_ext, dr_ext, dc_ext;
    logic             same_sq, off_board;
    logic [DIM_W-1:0] nb_row, nb_col;
    logic             on_board;
    logic [CW-1:0]    dist_inc;

    assign sr_ext   = CMP_W'(start_row);
    assign sc_ext   = CMP_W'(start_col);
    assign dr_ext   = CMP_W'(dest_row);
    assign dc_ext   = CMP_W'(dest_col);
    assign same_sq  = (start_row == dest_row) && (start_col == dest_col);
    assign off_board = (sr_ext >= CMP_W'(rows)) || (sc_ext >= CMP_W'(cols))
                    || (dr_ext >= CMP_W'(rows)) || (dc_ext >= CMP_W'(cols));
    assign dist_inc = cur_dist_reg + CW'(1);

    knm_step_unit #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W),
        .ROWS_W  (ROWS_W)
    ) u_step (
        .cur_row  (cur_row_reg),
        .cur_col  (cur_col_reg),
        .k        (k_reg),
        .rows     (rows),
        .cols     (cols),
        .nb_row   (nb_row),
        .nb_col   (nb_col),
        .on_board (on_board)
    );

    // state and counter registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= knm_pkg::ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    // working payload registers
    always_ff @(posedge aclk) begin
        start_row_reg <= start_row_next;
        start_col_reg <= start_col_next;
        dest_row_reg  <= dest_row_next;
        dest_col_reg  <= dest_col_next;
        cur_row_reg   <= cur_row_next;
        cur_col_reg   <= cur_col_next;
        cur_dist_reg  <= cur_dist_next;
        k_reg         <= k_next;
        clr_reg       <= clr_next;
        reach_reg     <= reach_next;
        count_reg     <= count_next;
    end

    // next state and register updates
    always_comb begin
        state_next     = state_reg;
        start_row_next = start_row_reg;
        start_col_next = start_col_reg;
        dest_row_next  = dest_row_reg;
        dest_col_next  = dest_col_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        cur_dist_next  = cur_dist_reg;
        k_next         = k_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        clr_next       = clr_reg;
        reach_next     = reach_reg;
        count_next     = count_reg;
        case (state_reg)
            knm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    start_row_next = sr_ext[DIM_W-1:0];
                    start_col_next = sc_ext[DIM_W-1:0];
                    dest_row_next  = dr_ext[DIM_W-1:0];
                    dest_col_next  = dc_ext[DIM_W-1:0];
                    count_next     = '0;
                    clr_next       = '0;
                    if (same_sq) begin
                        reach_next = 1'b1;
                        state_next = knm_pkg::ST_DONE;
                    end else if (off_board) begin
                        reach_next = 1'b0;
                        state_next = knm_pkg::ST_DONE;
                    end else begin
                        state_next = knm_pkg::ST_CLEAR;
                    end
                end
            end
            knm_pkg::ST_CLEAR: begin
                clr_next = clr_reg + IDX_W'(1);
                if (&clr_reg) begin
                    state_next = knm_pkg::ST_SEED;
                end
            end
            knm_pkg::ST_SEED: begin
                head_next  = '0;
                tail_next  = QC_W'(1);
                state_next = knm_pkg::ST_POP;
            end
            knm_pkg::ST_POP: begin
                if (head_reg == tail_reg) begin
                    state_next = knm_pkg::ST_LOOK;
                end else begin
                    head_next  = head_reg + QC_W'(1);
                    state_next = knm_pkg::ST_LOAD;
                end
            end
            knm_pkg::ST_LOAD: begin
                cur_dist_next = q_rdata[Q_W-1:IDX_W];
                cur_row_next  = q_rdata[IDX_W-1:DIM_W];
                cur_col_next  = q_rdata[DIM_W-1:0];
                k_next        = '0;
                state_next    = knm_pkg::ST_NB_CALC;
            end
            knm_pkg::ST_NB_CALC: begin
                if (on_board) begin
                    state_next = knm_pkg::ST_NB_CHECK;
                end else if (k_reg == 3'd7) begin
                    state_next = knm_pkg::ST_POP;
                end else begin
                    k_next = k_reg + 3'd1;
                end
            end
            knm_pkg::ST_NB_CHECK: begin
                if (!mem_rdata[CW]) begin
                    tail_next = tail_reg + QC_W'(1);
                end
                if (k_reg == 3'd7) begin
                    state_next = knm_pkg::ST_POP;
                end else begin
                    k_next     = k_reg + 3'd1;
                    state_next = knm_pkg::ST_NB_CALC;
                end
            end
            knm_pkg::ST_LOOK: begin
                state_next = knm_pkg::ST_LOOK_WAIT;
            end
            knm_pkg::ST_LOOK_WAIT: begin
                reach_next = mem_rdata[CW];
                count_next = mem_rdata[CW] ? mem_rdata[CW-1:0] : '0;
                state_next = knm_pkg::ST_DONE;
            end
            knm_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = knm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = knm_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs: handshake, store strobes and addresses
    always_comb begin
        s_ready    = 1'b0;
        res_load   = 1'b0;
        ctl.mem_we = 1'b0;
        ctl.q_we   = 1'b0;
        mem_addr   = {nb_row, nb_col};
        mem_wdata  = {1'b1, dist_inc};
        q_waddr    = tail_reg[IDX_W-1:0];
        q_wdata    = {dist_inc, nb_row, nb_col};
        q_raddr    = head_reg[IDX_W-1:0];
        case (state_reg)
            knm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            knm_pkg::ST_CLEAR: begin
                ctl.mem_we = 1'b1;
                mem_addr   = clr_reg;
                mem_wdata  = '0;
            end
            knm_pkg::ST_SEED: begin
                ctl.mem_we = 1'b1;
                ctl.q_we   = 1'b1;
                mem_addr   = {start_row_reg, start_col_reg};
                mem_wdata  = {1'b1, {CW{1'b0}}};
                q_waddr    = '0;
                q_wdata    = {{CW{1'b0}}, start_row_reg, start_col_reg};
            end
            knm_pkg::ST_NB_CHECK: begin
                ctl.mem_we = !mem_rdata[CW];
                ctl.q_we   = !mem_rdata[CW];
            end
            knm_pkg::ST_LOOK: begin
                mem_addr = {dest_row_reg, dest_col_reg};
            end
            knm_pkg::ST_DONE: begin
                res_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign res_reachable = reach_reg;
    assign res_count     = count_reg;

`ifndef NO_ASSERTIONS
    // the queue never pops past what was pushed
    a_head_le_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    // the queue holds at most one entry per square
    a_tail_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_reg <= QC_W'(DEPTH))
        else $error("queue overflow");

    // a square is marked only once per query
    a_mark_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == knm_pkg::ST_NB_CHECK && ctl.mem_we) |-> !mem_rdata[CW])
        else $error("visited square written again");

    // an accepted item always leaves the idle state
    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg != knm_pkg::ST_IDLE)
        else $error("accepted item not started");
`endif

endmodule

@@ src/knight_min_moves_bfs.sv @@
// Top level: knight shortest-path search with APB configuration and result register.
//
// Usage:
//  - Input channel s_*: one item is a start and a destination square. s_ready is high
//    only while the sequencer is idle; one item is searched at a time.
//  - Result channel m_*: one item per input, m_reachable and m_move_count, held in an
//    output register until m_ready. The next input is taken while a result waits.
//  - APB port: num_rows at 0x0, num_cols at 0x4; write only while idle.
// Sequence: a same-square or off-board item goes straight to the result. A search first
//  clears the square store, one entry a cycle, then pops each queued square and loads
//  it, tries each knight move in turn and checks each move that lands on the board
//  against the single-port square store, and at the end looks up the destination square.
// Reset: synchronous, active low; the board returns to 8 by 8, the output register
//  empties and the sequencer idles. The store needs no clearing after reset.
// Stall: a held result keeps the finished search waiting in its last state until the
//  output register is free.
module knight_min_moves_bfs #(
    parameter int MAX_DIM = knm_pkg::MAX_DIM_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [knm_pkg::COORD_W-1:0]   s_start_row,
    input  logic [knm_pkg::COORD_W-1:0]   s_start_col,
    input  logic [knm_pkg::COORD_W-1:0]   s_dest_row,
    input  logic [knm_pkg::COORD_W-1:0]   s_dest_col,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_reachable,
    output logic [knm_pkg::COUNT_W-1:0]   m_move_count
);
    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int ROWS_W = $clog2(MAX_DIM + 1);
    localparam int IDX_W  = 2 * DIM_W;
    localparam int Q_W    = knm_pkg::COUNT_W + IDX_W;
    localparam int CMP_W  = (ROWS_W > knm_pkg::CFG_W) ? ROWS_W : knm_pkg::CFG_W;
    localparam int CFGW   = knm_pkg::CFG_W;

    logic [CFGW-1:0] rows_reg, rows_next, cols_reg, cols_next;
    logic            m_valid_reg, m_valid_next;
    logic            m_reach_reg, m_reach_next;
    logic [knm_pkg::COUNT_W-1:0] m_count_reg, m_count_next;

    logic [ROWS_W-1:0] rows_use, cols_use;
    logic              cfg_wr, out_free, res_load, res_reachable;
    logic [knm_pkg::COUNT_W-1:0] res_count;
    knm_pkg::store_ctl_t          ctl;
    logic [IDX_W-1:0]             mem_addr, q_waddr, q_raddr;
    logic [knm_pkg::CELL_W-1:0]   mem_wdata, mem_rdata;
    logic [Q_W-1:0]               q_wdata, q_rdata;

    // configuration registers
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_wr) begin
            case (paddr[2])
                knm_pkg::REG_NUM_ROWS: rows_next = pwdata[CFGW-1:0];
                knm_pkg::REG_NUM_COLS: cols_next = pwdata[CFGW-1:0];
                default: rows_next = rows_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            knm_pkg::REG_NUM_ROWS: prdata = 32'(rows_reg);
            knm_pkg::REG_NUM_COLS: prdata = 32'(cols_reg);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= CFGW'(8);
            cols_reg <= CFGW'(8);
        end else begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    // board size limited to MAX_DIM
    assign rows_use = (CMP_W'(rows_reg) > CMP_W'(MAX_DIM)) ? ROWS_W'(MAX_DIM)
                                                           : ROWS_W'(rows_reg);
    assign cols_use = (CMP_W'(cols_reg) > CMP_W'(MAX_DIM)) ? ROWS_W'(MAX_DIM)
                                                           : ROWS_W'(cols_reg);

    // result register
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_reach_next = m_reach_reg;
        m_count_next = m_count_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_load) begin
            m_valid_next = 1'b1;
            m_reach_next = res_reachable;
            m_count_next = res_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_reach_reg <= m_reach_next;
        m_count_reg <= m_count_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_reachable  = m_reach_reg;
    assign m_move_count = m_count_reg;

    knm_ctrl #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W),
        .ROWS_W  (ROWS_W),
        .IDX_W   (IDX_W),
        .Q_W     (Q_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rows          (rows_use),
        .cols          (cols_use),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .start_row     (s_start_row),
        .start_col     (s_start_col),
        .dest_row      (s_dest_row),
        .dest_col      (s_dest_col),
        .out_free      (out_free),
        .res_load      (res_load),
        .res_reachable (res_reachable),
        .res_count     (res_count),
        .ctl           (ctl),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .mem_rdata     (mem_rdata),
        .q_waddr       (q_waddr),
        .q_wdata       (q_wdata),
        .q_raddr       (q_raddr),
        .q_rdata       (q_rdata)
    );

    knm_store #(
        .MAX_DIM (MAX_DIM),
        .IDX_W   (IDX_W),
        .Q_W     (Q_W)
    ) u_store (
        .aclk      (aclk),
        .ctl       (ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .q_waddr   (q_waddr),
        .q_wdata   (q_wdata),
        .q_raddr   (q_raddr),
        .q_rdata   (q_rdata)
    );

endmodule
